@@ src/lsbse_pkg.sv @@
package lsbse_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned BIT_IDX_W = 3;
   localparam int unsigned GROUP_W   = 9;
   localparam int unsigned PIX_W     = 24;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 24;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MSG_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXELS  = 2'd2;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_DONE   = 2'd2
   } phase_type;

   typedef struct packed {
      logic              mode;
      logic [BYTE_W-1:0] message_length;
      logic [PIX_W-1:0]  pixel_count;
   } cfg_type;

   typedef struct packed {
      logic [BIT_IDX_W-1:0] bit_index;
      logic [GROUP_W-1:0]   group_count;
      logic [BYTE_W-1:0]    held_byte;
      logic [BYTE_W-1:0]    decoded_length;
      phase_type            phase;
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] out_byte;
      logic              is_message;
      logic              last;
   } result_type;

endpackage

@@ src/lsbse_if.sv @@
interface lsbse_req_if;
   logic                      valid;
   logic                      ready;
   logic [lsbse_pkg::BYTE_W-1:0] carrier_byte;
   logic [lsbse_pkg::BYTE_W-1:0] message_byte;

   modport source (output valid, output carrier_byte, output message_byte, input ready);
   modport sink (input valid, input carrier_byte, input message_byte, output ready);
endinterface

interface lsbse_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lsbse_pkg::BYTE_W-1:0] out_byte;
   logic                      is_message;
   logic                      last;

   modport source (output valid, output out_byte, output is_message, output last, input ready);
   modport sink (input valid, input out_byte, input is_message, input last, output ready);
endinterface

interface lsbse_csr_if;
   logic                            valid;
   logic                            ready;
   logic [lsbse_pkg::CSR_IDX_W-1:0] reg_index;
   logic [lsbse_pkg::CSR_DAT_W-1:0] wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

@@ src/lsb_stego_embed_extract.sv @@
// LSB steganography embed / extract over a stream of image data bytes.
// req_ch : one carrier byte per transaction, plus the message byte that is
//          sampled on the first carrier of each group of eight.
// rsp_ch : encode (mode 0) gives one transaction per carrier, LSB replaced
//          inside the length-prefixed region, last on its final carrier.
//          Decode (mode 1) gives one transaction per eight body carriers with
//          the recovered message byte, is_message set, last on the final one.
// csr_ch : register writes (0 mode, 1 message length, 2 pixel count), always
//          ready; write only while the stream is idle.
// Latency: a result appears on rsp_ch the cycle after its carrier is taken.
// Throughput: one carrier per cycle while rsp_ch is not stalled; the bit
// replace / collect and the capacity clamp (two adds and a compare) sit in
// one stage between the stream state and the output register.
// Stall: when the output register holds a result that is not taken, req_ch
// ready drops; it is high again in the cycle rsp_ch ready returns.
// Reset: config, output valid and stream state clear to zero (header phase).
// A new image needs a reset.
module lsb_stego_embed_extract (
   input logic              clock,
   input logic              reset,
   lsbse_req_if.sink        req_ch,
   lsbse_rsp_if.source      rsp_ch,
   lsbse_csr_if.sink        csr_ch
);
   import lsbse_pkg::*;

   cfg_type           cfg_ff;
   state_type         state_ff;
   state_type         state_in;
   result_type        res;
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              is_message_ff;
   logic              last_ff;
   logic              req_fire;
   logic              csr_fire;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid;

   lsbse_step u_step (
      .cfg          (cfg_ff),
      .st           (state_ff),
      .carrier_byte (req_ch.carrier_byte),
      .message_byte (req_ch.message_byte),
      .st_in        (state_in),
      .res          (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         state_ff     <= '{bit_index: '0, group_count: '0, held_byte: '0,
                           decoded_length: '0, phase: PH_HEADER};
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_fire) begin
            unique case (csr_ch.reg_index)
               CSR_MODE:    cfg_ff.mode           <= csr_ch.wdata[0];
               CSR_MSG_LEN: cfg_ff.message_length <= csr_ch.wdata[BYTE_W-1:0];
               CSR_PIXELS:  cfg_ff.pixel_count    <= csr_ch.wdata[PIX_W-1:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            state_ff <= state_in;
         end
         if (req_ch.ready) begin
            rsp_valid_ff <= req_fire && res.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         out_byte_ff   <= res.out_byte;
         is_message_ff <= res.is_message;
         last_ff       <= res.last;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_byte   = out_byte_ff;
   assign rsp_ch.is_message = is_message_ff;
   assign rsp_ch.last       = last_ff;

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |-> !req_ch.ready)
      else $error("input accepted while result stalled");

   a_encode_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && cfg_ff.mode == MODE_ENCODE |=> rsp_ch.valid && !rsp_ch.is_message)
      else $error("encode carrier produced no result");

   a_decode_mid_group_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && cfg_ff.mode == MODE_DECODE && state_ff.bit_index != {BIT_IDX_W{1'b1}}
      |=> !rsp_ch.valid)
      else $error("decode result before group complete");

   a_encode_last_on_group_end: assert property (@(posedge clock) disable iff (reset)
      req_fire && cfg_ff.mode == MODE_ENCODE && state_ff.bit_index != {BIT_IDX_W{1'b1}}
      |=> !rsp_ch.last)
      else $error("encode last not on final carrier of a group");

endmodule

@@ src/lsbse_step.sv @@
module lsbse_step (
   input  lsbse_pkg::cfg_type                 cfg,
   input  lsbse_pkg::state_type               st,
   input  logic [lsbse_pkg::BYTE_W-1:0]       carrier_byte,
   input  logic [lsbse_pkg::BYTE_W-1:0]       message_byte,
   output lsbse_pkg::state_type               st_in,
   output lsbse_pkg::result_type              res
);
   import lsbse_pkg::*;

   logic [PIX_W+1:0]     pix_x3;
   logic [PIX_W-2:0]     capacity;
   logic [GROUP_W-1:0]   len_p1;
   logic [GROUP_W-1:0]   eff;
   logic [GROUP_W-1:0]   eff_m1;
   logic [GROUP_W-1:0]   group_inc;
   logic [BIT_IDX_W-1:0] bit_inc;
   logic                 group_end;
   logic [BYTE_W-1:0]    enc_held;
   logic [BYTE_W-1:0]    dec_held;

   // capacity = pixels * 3 / 8
   assign pix_x3    = {2'b00, cfg.pixel_count} + {1'b0, cfg.pixel_count, 1'b0};
   assign capacity  = pix_x3[PIX_W+1:3];
   assign len_p1    = {1'b0, cfg.message_length} + GROUP_W'(1);
   assign eff       = (capacity < (PIX_W-1)'(len_p1)) ? capacity[GROUP_W-1:0] : len_p1;
   assign eff_m1    = eff - GROUP_W'(1);
   assign group_inc = st.group_count + GROUP_W'(1);
   assign bit_inc   = st.bit_index + BIT_IDX_W'(1);
   assign group_end = (st.bit_index == {BIT_IDX_W{1'b1}});

   assign enc_held = (st.bit_index != '0) ? st.held_byte :
                     (st.group_count == '0) ? eff_m1[BYTE_W-1:0] : message_byte;
   assign dec_held = (st.bit_index == '0) ? {{(BYTE_W-1){1'b0}}, carrier_byte[0]} :
                     (st.held_byte | ({{(BYTE_W-1){1'b0}}, carrier_byte[0]} << st.bit_index));

   always_comb begin
      st_in          = st;
      res.valid      = 1'b0;
      res.out_byte   = carrier_byte;
      res.is_message = 1'b0;
      res.last       = 1'b0;
      if (cfg.mode == MODE_ENCODE) begin
         res.valid = 1'b1;
         if (st.phase != PH_DONE && st.group_count < eff) begin
            st_in.held_byte = enc_held;
            res.out_byte    = {carrier_byte[BYTE_W-1:1], enc_held[st.bit_index]};
            res.last        = group_end && (st.group_count == eff_m1);
            st_in.bit_index = bit_inc;
            if (group_end) begin
               st_in.group_count = group_inc;
               st_in.phase       = (group_inc >= eff) ? PH_DONE : PH_BODY;
            end
         end
      end else if (st.phase != PH_DONE) begin
         if (st.group_count != '0 && st.group_count > {1'b0, st.decoded_length}) begin
            st_in.phase = PH_DONE;
         end else begin
            st_in.held_byte = dec_held;
            st_in.bit_index = bit_inc;
            if (group_end) begin
               st_in.group_count = group_inc;
               if (st.group_count == '0) begin
                  st_in.decoded_length = dec_held;
                  st_in.phase          = (dec_held == '0) ? PH_DONE : PH_BODY;
               end else begin
                  res.valid      = 1'b1;
                  res.out_byte   = dec_held;
                  res.is_message = 1'b1;
                  res.last       = (st.group_count == {1'b0, st.decoded_length});
                  st_in.phase    = (group_inc > {1'b0, st.decoded_length}) ? PH_DONE
                                                                          : PH_BODY;
               end
            end
         end
      end
   end

endmodule

@@ test/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lsbse_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 3;
   localparam int unsigned DRAIN_CYCLES  = 8;
   localparam int unsigned END_GROUP     = 185;
   localparam int unsigned PRINT_CAP     = 200;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [PIX_W-1:0]     PIX_MAX   = 24'hFFFFFF;

   typedef enum logic [1:0] {
      CHK_MODEL = 2'd0,
      CHK_NONE  = 2'd1,
      CHK_BYTE  = 2'd2
   } row_check_type;

   typedef enum logic [1:0] {
      ROW_CARRIER = 2'd0,
      ROW_WRITE   = 2'd1
   } row_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              is_message;
      logic              last;
   } out_item_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DAT_W-1:0]  wdata;
      logic [BYTE_W-1:0]     carrier;
      logic [BYTE_W-1:0]     message;
      row_check_type         check;
      out_item_type          want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lsbse_req_if req_ch();
   lsbse_rsp_if rsp_ch();
   lsbse_csr_if csr_ch();

   lsb_stego_embed_extract dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #2 clock = ~clock;

   // stream model state and register copy
   cfg_type       cfg;
   state_type     st;
   out_item_type  out_bytes_due[$];

   row_check_type row_check = CHK_MODEL;
   out_item_type  row_want  = '0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned cycle_count    = 0;
   int unsigned errors         = 0;
   int unsigned carriers_taken = 0;
   int unsigned embedded       = 0;
   int unsigned passed         = 0;
   int unsigned extracted      = 0;
   int unsigned results_seen   = 0;
   int unsigned lasts_seen     = 0;
   int unsigned csr_writes     = 0;
   int unsigned n_random       = 0;

   task automatic flag_mismatch(input string what);
      errors++;
      if (errors <= PRINT_CAP)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic bump_bit();
      st.bit_index = st.bit_index + 1'b1;
      if (st.bit_index == 0)
         st.group_count = st.group_count + 1'b1;
   endtask

   // One carrier through the embed / extract rules; produced is 0 when no
   // transaction comes out on the result side.
   task automatic stego_step(input logic [BYTE_W-1:0] carrier,
                             input logic [BYTE_W-1:0] msg,
                             output bit produced, output out_item_type res);
      int unsigned cap;
      int unsigned eff;
      logic        b;
      produced = 1'b0;
      res      = '0;
      if (cfg.mode == MODE_ENCODE) begin
         cap = (32'(cfg.pixel_count) * 32'd3) / 32'd8;
         eff = 32'(cfg.message_length) + 32'd1;
         if (cap < eff)
            eff = cap;
         produced = 1'b1;
         if (st.phase >= PH_DONE || 32'(st.group_count) >= eff) begin
            res.out_byte = carrier;
            passed++;
            return;
         end
         if (st.bit_index == 0)
            st.held_byte = (st.group_count == 0) ? 8'(eff - 32'd1) : msg;
         b = st.held_byte[st.bit_index];
         res.out_byte = {carrier[BYTE_W-1:1], b};
         res.last = (st.bit_index == 3'd7 && 32'(st.group_count) == eff - 32'd1);
         embedded++;
         bump_bit();
         if (st.bit_index == 0) begin
            if (32'(st.group_count) >= eff)
               st.phase = PH_DONE;
            else
               st.phase = PH_BODY;
         end
         return;
      end

      if (st.phase >= PH_DONE)
         return;
      if (st.group_count != 0 && st.group_count > {1'b0, st.decoded_length}) begin
         st.phase = PH_DONE;
         return;
      end
      if (st.bit_index == 0)
         st.held_byte = {7'd0, carrier[0]};
      else
         st.held_byte = st.held_byte | (8'(carrier[0]) << st.bit_index);
      if (st.bit_index != 3'd7) begin
         bump_bit();
         return;
      end
      if (st.group_count == 0) begin
         st.decoded_length = st.held_byte;
         bump_bit();
         if (st.decoded_length == 0)
            st.phase = PH_DONE;
         else
            st.phase = PH_BODY;
         return;
      end
      res.out_byte   = st.held_byte;
      res.is_message = 1'b1;
      res.last       = (st.group_count == {1'b0, st.decoded_length});
      produced       = 1'b1;
      extracted++;
      bump_bit();
      if (st.group_count > {1'b0, st.decoded_length})
         st.phase = PH_DONE;
      else
         st.phase = PH_BODY;
   endtask

   always @(posedge clock) begin : watch
      out_item_type got;
      out_item_type want;
      out_item_type res;
      bit           produced;
      if (reset) begin
         cfg = '0;
         st  = '0;
         out_bytes_due.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.out_byte   = rsp_ch.out_byte;
            got.is_message = rsp_ch.is_message;
            got.last       = rsp_ch.last;
            results_seen++;
            if (got.last === 1'b1)
               lasts_seen++;
            if (out_bytes_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected result %02h", got.out_byte));
            end else begin
               want = out_bytes_due.pop_front();
               if (got.out_byte !== want.out_byte)
                  flag_mismatch($sformatf("out_byte %02h, want %02h",
                                          got.out_byte, want.out_byte));
               if (got.is_message !== want.is_message)
                  flag_mismatch($sformatf("is_message %b, want %b",
                                          got.is_message, want.is_message));
               if (got.last !== want.last)
                  flag_mismatch($sformatf("last %b, want %b", got.last, want.last));
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            csr_writes++;
            case (csr_ch.reg_index)
               CSR_MODE:    cfg.mode           = csr_ch.wdata[0];
               CSR_MSG_LEN: cfg.message_length = csr_ch.wdata[BYTE_W-1:0];
               CSR_PIXELS:  cfg.pixel_count    = csr_ch.wdata[PIX_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            carriers_taken++;
            stego_step(req_ch.carrier_byte, req_ch.message_byte, produced, res);
            case (row_check)
               CHK_MODEL: if (produced) out_bytes_due.push_back(res);
               CHK_BYTE:  out_bytes_due.push_back(row_want);
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cycle limit reached with %0d results outstanding",
                  out_bytes_due.size());
         $display("lsb_stego_embed_extract test failed");
         $finish;
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic push_carrier(input logic [BYTE_W-1:0] c, input logic [BYTE_W-1:0] m,
                               input row_check_type chk, input out_item_type want);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      row_check = chk;
      row_want  = want;
      req_ch.valid        <= 1'b1;
      req_ch.carrier_byte <= c;
      req_ch.message_byte <= m;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic send_random();
      if (n_random < 550) begin
         send_idle_pct  = 10;
         recv_stall_pct = 69;
      end else if (n_random < 1100) begin
         send_idle_pct  = 69;
         recv_stall_pct = 10;
      end else begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end
      n_random++;
      push_carrier(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), CHK_MODEL, '0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wdata     <= data;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // stop the stream and let every outstanding transaction drain
   task automatic settle_stream();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (out_bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic stim_row_type carrier_row(input logic [BYTE_W-1:0] c,
                                                input logic [BYTE_W-1:0] m,
                                                input row_check_type chk,
                                                input logic [BYTE_W-1:0] eb);
      stim_row_type r;
      r           = '0;
      r.kind      = ROW_CARRIER;
      r.carrier   = c;
      r.message   = m;
      r.check     = chk;
      r.want      = '{eb, 1'b0, 1'b0};
      return r;
   endfunction

   function automatic stim_row_type write_row(input logic [CSR_IDX_W-1:0] idx,
                                              input logic [CSR_DAT_W-1:0] data);
      stim_row_type r;
      r           = '0;
      r.kind      = ROW_WRITE;
      r.reg_index = idx;
      r.wdata     = data;
      r.check     = CHK_NONE;
      return r;
   endfunction

   initial begin
      stim_row_type rows[$];
      int unsigned  grp;
      int unsigned  pick;
      int unsigned  len;
      int unsigned  msg_len;
      int unsigned  pix;
      int unsigned  k;

      req_ch.valid        = 1'b0;
      req_ch.carrier_byte = '0;
      req_ch.message_byte = '0;
      csr_ch.valid        = 1'b0;
      csr_ch.reg_index    = CSR_MODE;
      csr_ch.wdata        = '0;

      // reset values: capacity zero, everything passes
      rows.push_back(carrier_row(8'h00, 8'hFF, CHK_BYTE, 8'h00));
      rows.push_back(carrier_row(8'hFF, 8'h00, CHK_BYTE, 8'hFF));
      rows.push_back(carrier_row(8'hA5, 8'h5A, CHK_BYTE, 8'hA5));
      // capacity under one byte with the longest message
      rows.push_back(write_row(CSR_MSG_LEN, 24'd255));
      rows.push_back(write_row(CSR_PIXELS, 24'd2));
      rows.push_back(carrier_row(8'h55, 8'hAA, CHK_BYTE, 8'h55));
      rows.push_back(carrier_row(8'hFE, 8'h01, CHK_BYTE, 8'hFE));
      rows.push_back(write_row(CSR_SPARE, PIX_MAX));
      rows.push_back(carrier_row(8'h01, 8'h80, CHK_BYTE, 8'h01));
      // decode header, length 200 LSB first
      rows.push_back(write_row(CSR_PIXELS, PIX_MAX));
      rows.push_back(write_row(CSR_MODE, CSR_DAT_W'(MODE_DECODE)));
      rows.push_back(carrier_row(8'hFE, 8'h00, CHK_NONE, 8'h00));
      rows.push_back(carrier_row(8'h00, 8'hFF, CHK_NONE, 8'h00));
      rows.push_back(carrier_row(8'h7E, 8'h11, CHK_NONE, 8'h00));
      rows.push_back(carrier_row(8'hFF, 8'h22, CHK_NONE, 8'h00));
      rows.push_back(carrier_row(8'h80, 8'h44, CHK_NONE, 8'h00));
      rows.push_back(carrier_row(8'h02, 8'h88, CHK_NONE, 8'h00));
      rows.push_back(carrier_row(8'h01, 8'h0F, CHK_NONE, 8'h00));
      rows.push_back(carrier_row(8'h81, 8'hF0, CHK_NONE, 8'h00));
      // switch to encode inside a group, then back to decode to finish it
      rows.push_back(write_row(CSR_MODE, CSR_DAT_W'(MODE_ENCODE)));
      rows.push_back(carrier_row(8'h3D, 8'h5A, CHK_MODEL, 8'h00));
      rows.push_back(carrier_row(8'hC2, 8'hA5, CHK_MODEL, 8'h00));
      rows.push_back(carrier_row(8'h00, 8'hFF, CHK_MODEL, 8'h00));
      rows.push_back(write_row(CSR_MODE, CSR_DAT_W'(MODE_DECODE)));
      rows.push_back(carrier_row(8'hFF, 8'h00, CHK_MODEL, 8'h00));
      rows.push_back(carrier_row(8'h00, 8'h00, CHK_MODEL, 8'h00));
      rows.push_back(carrier_row(8'h55, 8'hC3, CHK_MODEL, 8'h00));
      rows.push_back(carrier_row(8'hAA, 8'h3C, CHK_MODEL, 8'h00));
      rows.push_back(carrier_row(8'h01, 8'h7F, CHK_MODEL, 8'h00));
      // region already past the effective length: unchanged, no advance
      rows.push_back(write_row(CSR_MSG_LEN, 24'd0));
      rows.push_back(write_row(CSR_MODE, CSR_DAT_W'(MODE_ENCODE)));
      rows.push_back(carrier_row(8'h3C, 8'h99, CHK_BYTE, 8'h3C));
      rows.push_back(carrier_row(8'hC3, 8'h66, CHK_BYTE, 8'hC3));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct  = 10;
      recv_stall_pct = 69;
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_WRITE) begin
            settle_stream();
            write_reg(rows[i].reg_index, rows[i].wdata);
         end else begin
            push_carrier(rows[i].carrier, rows[i].message, rows[i].check, rows[i].want);
         end
      end

      while (st.phase != PH_DONE) begin
         settle_stream();
         grp = 32'(st.group_count);
         if (grp >= END_GROUP) begin
            // run to the end of the stream in one of the two modes
            if ($urandom_range(0, 1) == 1) begin
               write_reg(CSR_MODE, CSR_DAT_W'(MODE_ENCODE));
               if ($urandom_range(0, 1) == 1) begin
                  write_reg(CSR_MSG_LEN, 24'(grp));
                  write_reg(CSR_PIXELS, PIX_MAX);
               end else begin
                  write_reg(CSR_MSG_LEN, 24'd255);
                  write_reg(CSR_PIXELS, 24'(((grp + 1) * 8 + 2) / 3));
               end
            end else begin
               write_reg(CSR_MODE, CSR_DAT_W'(MODE_DECODE));
            end
            while (st.phase != PH_DONE)
               send_random();
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               write_reg(CSR_MODE, CSR_DAT_W'(MODE_DECODE));
               len = $urandom_range(1, 40);
            end else if (pick < 85) begin
               // effective length kept well ahead of the group count
               msg_len = $urandom_range(grp + 6, 255);
               case ($urandom_range(0, 2))
                  0: begin
                     pix = $urandom_range(0, PIX_MAX);
                     if ((pix * 3) / 8 < grp + 7)
                        pix = PIX_MAX;
                  end
                  1: begin
                     k   = $urandom_range(grp + 7, msg_len + 1);
                     pix = (k * 8 + 2) / 3;
                  end
                  default: pix = PIX_MAX;
               endcase
               write_reg(CSR_MODE, CSR_DAT_W'(MODE_ENCODE));
               write_reg(CSR_MSG_LEN, 24'(msg_len));
               write_reg(CSR_PIXELS, 24'(pix));
               len = $urandom_range(1, 40);
            end else begin
               write_reg(CSR_MODE, CSR_DAT_W'(MODE_ENCODE));
               if ($urandom_range(0, 1) == 1) begin
                  write_reg(CSR_MSG_LEN, 24'($urandom_range(0, grp - 2)));
                  write_reg(CSR_PIXELS, 24'($urandom_range(0, PIX_MAX)));
               end else begin
                  write_reg(CSR_MSG_LEN, 24'($urandom_range(0, 255)));
                  write_reg(CSR_PIXELS, 24'($urandom_range(0, 2)));
               end
               len = $urandom_range(1, 6);
            end
            repeat (len) send_random();
         end
      end

      // stream finished: encode passes bytes through, decode stays silent
      settle_stream();
      write_reg(CSR_MODE, CSR_DAT_W'(MODE_ENCODE));
      write_reg(CSR_MSG_LEN, 24'($urandom_range(0, 255)));
      write_reg(CSR_PIXELS, 24'($urandom_range(0, PIX_MAX)));
      repeat (20) send_random();
      settle_stream();
      write_reg(CSR_MODE, CSR_DAT_W'(MODE_DECODE));
      repeat (10) send_random();
      settle_stream();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d carriers: %0d embedded a bit, %0d passed unchanged, %0d bytes extracted",
               carriers_taken, embedded, passed, extracted);
      $display("%0d results checked (%0d with last), %0d register writes, %0d errors",
               results_seen, lasts_seen, csr_writes, errors);
      if (errors == 0)
         $display("lsb_stego_embed_extract test passed");
      else
         $display("lsb_stego_embed_extract test failed");
      $finish;
   end

endmodule
